// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SVFS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svfs check failed");

// Next-cycle implication, disabled while reset is held.
`define SVFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svfs check failed");

`endif

// ===== design/svfs_pkg.sv =====
package svfs_pkg;

    // Fixed field widths of the word channels.
    localparam int unsigned OP_BITS      = 3;
    localparam int unsigned NAME_ID_BITS = 16;
    localparam int unsigned INDEX_BITS   = 8;
    localparam int unsigned WORD_BITS    = 32;
    localparam int unsigned SIZE_BITS    = 9;
    localparam int unsigned STATUS_BITS  = 3;

    // Operation codes of an input word.
    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_DEFINE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_DUP   = 3'd2,
        ST_SIZE  = 3'd3,
        ST_UNDEF = 3'd4,
        ST_RANGE = 3'd5,
        ST_FULL  = 3'd6
    } t_status;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_POP_RD,
        S_DEF_RD,
        S_SCAN,
        S_FILL,
        S_ACCESS,
        S_RD_WAIT,
        S_FIN
    } t_state;

    // Report of the name search unit.
    typedef struct packed {
        logic done;
        logic found;
    } t_srch_res;

endpackage

// ===== design/scoped_variable_frame_stack_core.sv =====
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_op, i_name_id, i_word_index, i_write_value,
//                                        i_array_size
// output    o_out_valid / i_out_ready    o_read_value, o_status
//
// One word at a time. Push and pop need no scan; read and write scan N entry rows
// before the store access, and define scans N rows and then zero-fills S words, where
// N is the number of entry rows scanned (one per cycle through the entry table read
// port) and S the array size zero-filled (one word per cycle on the store write port).
// Reset clears only the state, the counters and the output valid; the tables need no clearing pass.
// A stalled output holds the finished result in the output register; the next word
// is accepted meanwhile and waits at the end of its work until the register frees.
module scoped_variable_frame_stack_core #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned MAX_FRAMES  = 32,
    parameter int unsigned STORE_WORDS = 4096,
    parameter int unsigned NAME_BITS   = 16,
    parameter int unsigned MAX_ARRAY   = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [svfs_pkg::OP_BITS-1:0]            i_op,
    input  logic [svfs_pkg::NAME_ID_BITS-1:0]       i_name_id,
    input  logic [svfs_pkg::INDEX_BITS-1:0]         i_word_index,
    input  logic signed [svfs_pkg::WORD_BITS-1:0]   i_write_value,
    input  logic [svfs_pkg::SIZE_BITS-1:0]          i_array_size,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [svfs_pkg::WORD_BITS-1:0]  o_read_value,
    output logic [svfs_pkg::STATUS_BITS-1:0]        o_status
);

    import svfs_pkg::*;

    localparam int unsigned EIW   = $clog2(MAX_ENTRIES);
    localparam int unsigned ECW   = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned FIW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned DCW   = $clog2(MAX_FRAMES + 1);
    localparam int unsigned SAW   = $clog2(STORE_WORDS);
    localparam int unsigned FPW   = $clog2(STORE_WORDS + 1);
    localparam int unsigned LW    = $clog2(MAX_ARRAY + 1);
    localparam int unsigned ENT_W = NAME_BITS + SAW + LW;
    localparam int unsigned FRM_W = ECW + FPW;

    // Sequencer and datapath registers.
    t_state                  r_state, n_state;
    logic [OP_BITS-1:0]      r_op, n_op;
    logic [NAME_BITS-1:0]    r_name, n_name;
    logic [INDEX_BITS-1:0]   r_idx, n_idx;
    logic [WORD_BITS-1:0]    r_wval, n_wval;
    logic [SIZE_BITS-1:0]    r_size, n_size;
    logic [DCW-1:0]          r_depth, n_depth;
    logic [ECW-1:0]          r_count, n_count;
    logic [FPW-1:0]          r_fp, n_fp;
    logic [SAW-1:0]          r_base, n_base;
    logic [LW-1:0]           r_len, n_len;
    logic [SAW-1:0]          r_fill_addr, n_fill_addr;
    logic [LW-1:0]           r_fill_left, n_fill_left;
    t_status                 r_res_status, n_res_status;
    logic [WORD_BITS-1:0]    r_res_val, n_res_val;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_out_status, n_out_status;
    logic [WORD_BITS-1:0]    r_out_val, n_out_val;

    // Memory ports.
    logic                    w_frm_we, w_frm_re;
    logic [FIW-1:0]          w_frm_waddr, w_frm_raddr;
    logic [FRM_W-1:0]        w_frm_wdata, w_frm_rdata;
    logic                    w_ent_we, w_ent_re;
    logic [EIW-1:0]          w_ent_raddr;
    logic [ENT_W-1:0]        w_ent_wdata, w_ent_rdata;
    logic                    w_wrd_we, w_wrd_re;
    logic [SAW-1:0]          w_wrd_waddr, w_wrd_raddr;
    logic [WORD_BITS-1:0]    w_wrd_wdata, w_wrd_rdata;

    // Search unit.
    logic                    w_srch_start;
    logic [ECW-1:0]          w_srch_lowest;
    t_srch_res               w_srch;

    // Decoded fields and checks.
    logic [ECW-1:0]          w_saved_cnt;
    logic [FPW-1:0]          w_saved_fp;
    logic [NAME_BITS-1:0]    w_ent_name;
    logic [SAW-1:0]          w_ent_base;
    logic [LW-1:0]           w_ent_len;
    logic [DCW-1:0]          w_depth_dec;
    logic [SAW:0]            w_addr_sum;
    logic                    w_size_bad;
    logic                    w_no_room;
    logic                    w_frames_full;
    logic                    w_range_bad;
    logic                    w_scoped_op;

    assign w_saved_cnt   = w_frm_rdata[FRM_W-1 -: ECW];
    assign w_saved_fp    = w_frm_rdata[FPW-1:0];
    assign w_ent_name    = w_ent_rdata[ENT_W-1 -: NAME_BITS];
    assign w_ent_base    = w_ent_rdata[LW+SAW-1 -: SAW];
    assign w_ent_len     = w_ent_rdata[LW-1:0];
    assign w_depth_dec   = r_depth - DCW'(1);
    assign w_addr_sum    = (SAW+1)'(r_base) + (SAW+1)'(r_idx);
    assign w_size_bad    = (r_size == '0) || (32'(r_size) > MAX_ARRAY);
    assign w_no_room     = (32'(r_count) >= MAX_ENTRIES)
                         || ((32'(r_fp) + 32'(r_size)) > STORE_WORDS);
    assign w_frames_full = 32'(r_depth) >= MAX_FRAMES;
    assign w_range_bad   = (32'(r_idx) >= 32'(r_len)) || (32'(w_addr_sum) >= STORE_WORDS);
    assign w_scoped_op   = (r_op == OP_POP) || (r_op == OP_DEFINE)
                         || (r_op == OP_READ) || (r_op == OP_WRITE);

    // Saved entry count and free pointer per frame.
    svfs_ram #(.DEPTH(MAX_FRAMES), .WIDTH(FRM_W), .AW(FIW)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_frm_we),
        .i_waddr (w_frm_waddr),
        .i_wdata (w_frm_wdata),
        .i_re    (w_frm_re),
        .i_raddr (w_frm_raddr),
        .o_rdata (w_frm_rdata)
    );

    // Entry table: name, base and length per defined array.
    svfs_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENT_W), .AW(EIW)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (r_count[EIW-1:0]),
        .i_wdata (w_ent_wdata),
        .i_re    (w_ent_re),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // Array storage.
    svfs_ram #(.DEPTH(STORE_WORDS), .WIDTH(WORD_BITS), .AW(SAW)) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_wrd_we),
        .i_waddr (w_wrd_waddr),
        .i_wdata (w_wrd_wdata),
        .i_re    (w_wrd_re),
        .i_raddr (w_wrd_raddr),
        .o_rdata (w_wrd_rdata)
    );

    svfs_search #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NAME_BITS   (NAME_BITS),
        .CNT_BITS    (ECW),
        .IDX_BITS    (EIW)
    ) u_search (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_srch_start),
        .i_lowest  (w_srch_lowest),
        .i_count   (r_count),
        .i_key     (r_name),
        .i_rd_name (w_ent_name),
        .o_rd_en   (w_ent_re),
        .o_rd_addr (w_ent_raddr),
        .o_res     (w_srch)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_scoped_op && (r_depth != '0)) begin
                    if (r_op == OP_POP) begin
                        n_state = S_POP_RD;
                    end else if (r_op == OP_DEFINE) begin
                        n_state = S_DEF_RD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_POP_RD:  n_state = S_FIN;
            S_DEF_RD:  n_state = S_SCAN;
            S_SCAN: begin
                if (w_srch.done) begin
                    if (r_op == OP_DEFINE) begin
                        n_state = (w_srch.found || w_size_bad || w_no_room) ? S_FIN : S_FILL;
                    end else begin
                        n_state = w_srch.found ? S_ACCESS : S_FIN;
                    end
                end
            end
            S_FILL: begin
                if (r_fill_left == LW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_ACCESS: begin
                n_state = (w_range_bad || (r_op == OP_WRITE)) ? S_FIN : S_RD_WAIT;
            end
            S_RD_WAIT: n_state = S_FIN;
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath control and register updates per state.
    always_comb begin
        n_op         = r_op;
        n_name       = r_name;
        n_idx        = r_idx;
        n_wval       = r_wval;
        n_size       = r_size;
        n_depth      = r_depth;
        n_count      = r_count;
        n_fp         = r_fp;
        n_base       = r_base;
        n_len        = r_len;
        n_fill_addr  = r_fill_addr;
        n_fill_left  = r_fill_left;
        n_res_status = r_res_status;
        n_res_val    = r_res_val;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_val    = r_out_val;
        w_frm_we      = 1'b0;
        w_frm_waddr   = r_depth[FIW-1:0];
        w_frm_wdata   = {r_count, r_fp};
        w_frm_re      = 1'b0;
        w_frm_raddr   = w_depth_dec[FIW-1:0];
        w_ent_we      = 1'b0;
        w_ent_wdata   = {r_name, r_fp[SAW-1:0], LW'(r_size)};
        w_wrd_we      = 1'b0;
        w_wrd_waddr   = r_fill_addr;
        w_wrd_wdata   = '0;
        w_wrd_re      = 1'b0;
        w_wrd_raddr   = w_addr_sum[SAW-1:0];
        w_srch_start  = 1'b0;
        w_srch_lowest = '0;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op         = i_op;
                    n_name       = NAME_BITS'(i_name_id);
                    n_idx        = i_word_index;
                    n_wval       = i_write_value;
                    n_size       = i_array_size;
                    n_res_status = ST_OK;
                    n_res_val    = '0;
                end
            end
            S_EXEC: begin
                if (r_op == OP_PUSH) begin
                    if (w_frames_full) begin
                        n_res_status = ST_FULL;
                    end else begin
                        w_frm_we = 1'b1;
                        n_depth  = r_depth + DCW'(1);
                    end
                end else if (w_scoped_op) begin
                    if (r_depth == '0) begin
                        n_res_status = ST_EMPTY;
                    end else if ((r_op == OP_POP) || (r_op == OP_DEFINE)) begin
                        w_frm_re = 1'b1;
                    end else begin
                        w_srch_start = 1'b1;
                    end
                end
            end
            S_POP_RD: begin
                n_count = w_saved_cnt;
                n_fp    = w_saved_fp;
                n_depth = w_depth_dec;
            end
            S_DEF_RD: begin
                // Duplicates are searched only within the top frame.
                w_srch_start  = 1'b1;
                w_srch_lowest = w_saved_cnt;
            end
            S_SCAN: begin
                if (w_srch.done) begin
                    if (r_op == OP_DEFINE) begin
                        if (w_srch.found) begin
                            n_res_status = ST_DUP;
                        end else if (w_size_bad) begin
                            n_res_status = ST_SIZE;
                        end else if (w_no_room) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_fill_addr = r_fp[SAW-1:0];
                            n_fill_left = LW'(r_size);
                        end
                    end else if (w_srch.found) begin
                        n_base = w_ent_base;
                        n_len  = w_ent_len;
                    end else begin
                        n_res_status = ST_UNDEF;
                    end
                end
            end
            S_FILL: begin
                // Zero one word per cycle; the entry row is added with the last one.
                w_wrd_we    = 1'b1;
                n_fill_addr = r_fill_addr + SAW'(1);
                n_fill_left = r_fill_left - LW'(1);
                if (r_fill_left == LW'(1)) begin
                    w_ent_we = 1'b1;
                    n_count  = r_count + ECW'(1);
                    n_fp     = r_fp + FPW'(r_size);
                end
            end
            S_ACCESS: begin
                if (w_range_bad) begin
                    n_res_status = ST_RANGE;
                end else if (r_op == OP_WRITE) begin
                    w_wrd_we    = 1'b1;
                    w_wrd_waddr = w_addr_sum[SAW-1:0];
                    w_wrd_wdata = r_wval;
                end else begin
                    w_wrd_re = 1'b1;
                end
            end
            S_RD_WAIT: begin
                n_res_val = w_wrd_rdata;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_val    = r_res_val;
                end
            end
            default: begin
                n_res_status = r_res_status;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_count     <= '0;
            r_fp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_count     <= n_count;
            r_fp        <= n_fp;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_name       <= n_name;
        r_idx        <= n_idx;
        r_wval       <= n_wval;
        r_size       <= n_size;
        r_base       <= n_base;
        r_len        <= n_len;
        r_fill_addr  <= n_fill_addr;
        r_fill_left  <= n_fill_left;
        r_res_status <= n_res_status;
        r_res_val    <= n_res_val;
        r_out_status <= n_out_status;
        r_out_val    <= n_out_val;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_val;
    assign o_status     = r_out_status;

endmodule

// ===== design/svfs_ram.sv =====
module svfs_ram #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/svfs_search.sv =====
module svfs_search #(
    parameter int unsigned MAX_ENTRIES = 64,
    parameter int unsigned NAME_BITS   = 16,
    parameter int unsigned CNT_BITS    = $clog2(MAX_ENTRIES + 1),
    parameter int unsigned IDX_BITS    = $clog2(MAX_ENTRIES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [CNT_BITS-1:0]      i_lowest,
    input  logic [CNT_BITS-1:0]      i_count,
    input  logic [NAME_BITS-1:0]     i_key,
    input  logic [NAME_BITS-1:0]     i_rd_name,
    output logic                     o_rd_en,
    output logic [IDX_BITS-1:0]      o_rd_addr,
    output svfs_pkg::t_srch_res      o_res
);

    import svfs_pkg::*;

    logic                r_busy, n_busy;
    logic                r_pend, n_pend;
    logic [CNT_BITS-1:0] r_next, n_next;
    logic [CNT_BITS-1:0] r_lowest, n_lowest;
    logic [CNT_BITS-1:0] w_dec;
    logic                w_hit;
    logic                w_issue;

    // Newest-first scan: one row fetched per cycle, the row fetched last cycle
    // is compared while the next one is fetched.
    always_comb begin
        w_dec    = r_next - CNT_BITS'(1);
        w_hit    = r_busy && r_pend && (i_rd_name == i_key);
        w_issue  = r_busy && !w_hit && (r_next > r_lowest);
        n_busy   = r_busy;
        n_pend   = r_pend;
        n_next   = r_next;
        n_lowest = r_lowest;
        o_rd_en   = w_issue;
        o_rd_addr = w_dec[IDX_BITS-1:0];
        o_res.done  = r_busy && !w_issue;
        o_res.found = w_hit;
        if (i_start) begin
            n_busy   = 1'b1;
            n_pend   = 1'b0;
            n_next   = i_count;
            n_lowest = i_lowest;
        end else if (r_busy) begin
            if (w_issue) begin
                n_next = w_dec;
                n_pend = 1'b1;
            end else begin
                n_busy = 1'b0;
                n_pend = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_pend <= n_pend;
        end
    end

    // Scan bounds.
    always_ff @(posedge i_clk) begin
        r_next   <= n_next;
        r_lowest <= n_lowest;
    end

endmodule

// ===== design/svfs_checker.sv =====
`include "assert_macros.svh"

module svfs_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic signed [svfs_pkg::WORD_BITS-1:0]  o_read_value,
    input logic [svfs_pkg::STATUS_BITS-1:0]       o_status
);

    import svfs_pkg::*;

    // A result word stays offered until it is taken.
    `SVFS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // The status code never takes the unused value.
    `SVFS_ASSERT_IMP(a_status_known, i_clk, i_rst_n, o_out_valid, o_status != 3'd7)

    // Any failed operation returns a zero word.
    `SVFS_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, o_out_valid && (o_status != ST_OK), o_read_value == '0)

    // Taking an input word starts its work, so the next cycle is never ready.
    `SVFS_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind scoped_variable_frame_stack_core svfs_checker u_svfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);

// ===== tb/testbench.sv =====
module testbench;
    import svfs_pkg::*;

    localparam int MAX_ENTRIES = 64;
    localparam int MAX_FRAMES  = 32;
    localparam int STORE_WORDS = 4096;
    localparam int MAX_ARRAY   = 256;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 400;

    // Op codes 5 to 7 are unused and must be answered with a plain ok.
    localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_BITS-1:0] OP_SPARE_MID   = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        logic signed [WORD_BITS-1:0] value;
        t_status                     status;
    } t_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_ready;
    logic [OP_BITS-1:0]                  i_op = '0;
    logic [NAME_ID_BITS-1:0]             i_name_id = '0;
    logic [INDEX_BITS-1:0]               i_word_index = '0;
    logic signed [WORD_BITS-1:0]         i_write_value = '0;
    logic [SIZE_BITS-1:0]                i_array_size = '0;
    logic                                o_out_valid;
    logic                                i_out_ready = 1'b0;
    logic signed [WORD_BITS-1:0]         o_read_value;
    logic [STATUS_BITS-1:0]              o_status;

    // Shadow of the scope stack used to predict every result word.
    logic [15:0]                 row_name [MAX_ENTRIES];
    logic [11:0]                 row_base [MAX_ENTRIES];
    logic [8:0]                  row_len  [MAX_ENTRIES];
    logic [6:0]                  row_count = '0;
    logic [5:0]                  scope_depth = '0;
    logic [6:0]                  frame_rows [MAX_FRAMES];
    logic [12:0]                 frame_free [MAX_FRAMES];
    logic signed [WORD_BITS-1:0] data_mem [STORE_WORDS];
    logic [12:0]                 next_free = '0;

    t_result expected_results [$];

    int idle_pct = 16;
    int stall_pct = 16;
    int words_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    scoped_variable_frame_stack_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_name_id     (i_name_id),
        .i_word_index  (i_word_index),
        .i_write_value (i_write_value),
        .i_array_size  (i_array_size),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_read_value  (o_read_value),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    // Newest-first name search down to the given row.
    function automatic int find_row(logic [15:0] nm, int lowest);
        for (int i = int'(row_count) - 1; i >= lowest; i--) begin
            if (row_name[i] == nm) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one accepted word to the shadow stack and queues its result.
    function automatic void predict_frame_stack(logic [2:0] op, logic [15:0] nm,
            logic [7:0] idx, logic signed [31:0] val, logic [8:0] sz);
        t_result r;
        int row;
        r.value = '0;
        r.status = ST_OK;
        case (op)
            OP_PUSH: begin
                if (scope_depth >= MAX_FRAMES) begin
                    r.status = ST_FULL;
                end else begin
                    frame_rows[scope_depth] = row_count;
                    frame_free[scope_depth] = next_free;
                    scope_depth++;
                end
            end
            OP_POP: begin
                if (scope_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    scope_depth--;
                    row_count = frame_rows[scope_depth];
                    next_free = frame_free[scope_depth];
                end
            end
            OP_DEFINE: begin
                if (scope_depth == 0) begin
                    r.status = ST_EMPTY;
                end else if (find_row(nm, int'(frame_rows[scope_depth - 1])) >= 0) begin
                    r.status = ST_DUP;
                end else if (sz < 1 || sz > MAX_ARRAY) begin
                    r.status = ST_SIZE;
                end else if (row_count >= MAX_ENTRIES
                        || int'(sz) > STORE_WORDS - int'(next_free)) begin
                    r.status = ST_FULL;
                end else begin
                    for (int k = 0; k < int'(sz); k++) begin
                        data_mem[int'(next_free) + k] = '0;
                    end
                    row_name[row_count] = nm;
                    row_base[row_count] = next_free[11:0];
                    row_len[row_count] = sz;
                    row_count++;
                    next_free = next_free + sz;
                end
            end
            OP_READ, OP_WRITE: begin
                if (scope_depth == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    row = find_row(nm, 0);
                    if (row < 0) begin
                        r.status = ST_UNDEF;
                    end else if (idx >= row_len[row]) begin
                        r.status = ST_RANGE;
                    end else if (op == OP_READ) begin
                        r.value = data_mem[int'(row_base[row]) + int'(idx)];
                    end else begin
                        data_mem[int'(row_base[row]) + int'(idx)] = val;
                    end
                end
            end
            default: begin
            end
        endcase
        expected_results = {expected_results, r};
    endfunction

    // Offers one word, with an occasional random gap, and predicts it once taken.
    task automatic send_word(input logic [2:0] op, input logic [15:0] nm,
            input logic [7:0] idx, input logic signed [31:0] val, input logic [8:0] sz);
        if ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < idle_pct);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_name_id <= nm;
        i_word_index <= idx;
        i_write_value <= val;
        i_array_size <= sz;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        words_sent++;
        predict_frame_stack(op, nm, idx, val, sz);
    endtask

    // Holds the input idle until every predicted result has come back.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (expected_results.size() != 0);
    endtask

    task automatic unwind_frames();
        while (scope_depth != 0) begin
            send_word(OP_POP, '0, '0, '0, '0);
        end
    endtask

    // Errors with no frame, define checks, zero fill, shadowing and spare ops.
    task automatic test_directed();
        send_word(OP_POP, 16'h0001, 8'd0, 32'sd0, 9'd0);
        send_word(OP_DEFINE, 16'h0001, 8'd0, 32'sd0, 9'd4);
        send_word(OP_READ, 16'h0001, 8'd0, 32'sd0, 9'd0);
        send_word(OP_WRITE, 16'h0001, 8'd0, 32'sd5, 9'd0);
        send_word(OP_PUSH, 16'h0000, 8'd0, 32'sd0, 9'd0);
        send_word(OP_DEFINE, 16'h0000, 8'd0, 32'sd0, 9'd1);
        send_word(OP_DEFINE, 16'h0000, 8'd0, 32'sd0, 9'd5);
        send_word(OP_DEFINE, 16'hFFFF, 8'd0, 32'sd0, 9'd0);
        send_word(OP_DEFINE, 16'hFFFF, 8'd0, 32'sd0, 9'd257);
        send_word(OP_DEFINE, 16'hFFFF, 8'd0, 32'sd0, 9'd511);
        send_word(OP_DEFINE, 16'hFFFF, 8'd0, 32'sd0, 9'd256);
        send_word(OP_WRITE, 16'hFFFF, 8'd255, 32'sh8000_0000, 9'd0);
        send_word(OP_READ, 16'hFFFF, 8'd255, 32'sd0, 9'd0);
        send_word(OP_READ, 16'hFFFF, 8'd0, 32'sd0, 9'd0);
        send_word(OP_WRITE, 16'h0000, 8'd1, 32'sh7FFF_FFFF, 9'd0);
        send_word(OP_READ, 16'h0000, 8'd255, 32'sd0, 9'd0);
        send_word(OP_READ, 16'h1234, 8'd0, 32'sd0, 9'd0);
        send_word(OP_SPARE_FIRST, 16'hFFFF, 8'd255, -32'sd1, 9'd511);
        send_word(OP_SPARE_MID, 16'hFFFF, 8'd255, -32'sd1, 9'd511);
        send_word(OP_SPARE_LAST, 16'hFFFF, 8'd255, -32'sd1, 9'd511);
        // The inner definition of the same name hides the outer one.
        send_word(OP_PUSH, 16'h0000, 8'd0, 32'sd0, 9'd0);
        send_word(OP_DEFINE, 16'hFFFF, 8'd0, 32'sd0, 9'd2);
        send_word(OP_WRITE, 16'hFFFF, 8'd1, 32'sh7FFF_FFFF, 9'd0);
        send_word(OP_READ, 16'hFFFF, 8'd200, 32'sd0, 9'd0);
        send_word(OP_POP, 16'h0000, 8'd0, 32'sd0, 9'd0);
        send_word(OP_READ, 16'hFFFF, 8'd255, 32'sd0, 9'd0);
        send_word(OP_POP, 16'h0000, 8'd0, 32'sd0, 9'd0);
        send_word(OP_READ, 16'hFFFF, 8'd255, 32'sd0, 9'd0);
    endtask

    // Fills the frame stack one past its depth, then unwinds it.
    task automatic test_frame_limit();
        repeat (MAX_FRAMES + 1) begin
            send_word(OP_PUSH, 16'($urandom), 8'($urandom), 32'($urandom), 9'($urandom));
        end
        send_word(OP_DEFINE, 16'h00AA, 8'd0, 32'sd0, 9'd3);
        send_word(OP_WRITE, 16'h00AA, 8'd2, 32'($urandom), 9'd0);
        send_word(OP_READ, 16'h00AA, 8'd2, 32'sd0, 9'd0);
        unwind_frames();
        send_word(OP_POP, 16'h0000, 8'd0, 32'sd0, 9'd0);
    endtask

    // Runs out of storage words, then out of entry rows.
    task automatic test_storage_limit();
        send_word(OP_PUSH, '0, '0, '0, '0);
        for (int i = 0; i < STORE_WORDS / MAX_ARRAY; i++) begin
            send_word(OP_DEFINE, 16'h0100 + 16'(i), 8'd0, 32'sd0, 9'd256);
        end
        send_word(OP_DEFINE, 16'h0200, 8'd0, 32'sd0, 9'd1);
        send_word(OP_WRITE, 16'h010F, 8'd255, 32'($urandom), 9'd0);
        send_word(OP_READ, 16'h010F, 8'd255, 32'sd0, 9'd0);
        send_word(OP_READ, 16'h0100, 8'd128, 32'sd0, 9'd0);
        send_word(OP_POP, '0, '0, '0, '0);

        send_word(OP_PUSH, '0, '0, '0, '0);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            send_word(OP_DEFINE, 16'h0300 + 16'(i), 8'd0, 32'sd0, 9'd1);
        end
        send_word(OP_DEFINE, 16'h0400, 8'd0, 32'sd0, 9'd1);
        send_word(OP_PUSH, '0, '0, '0, '0);
        send_word(OP_DEFINE, 16'h0300, 8'd0, 32'sd0, 9'd1);
        send_word(OP_WRITE, 16'h033F, 8'd0, 32'($urandom), 9'd0);
        send_word(OP_READ, 16'h033F, 8'd0, 32'sd0, 9'd0);
        unwind_frames();
    endtask

    // Scoped sessions with random content, mostly on names that exist.
    task automatic test_random(input int n_words);
        logic [15:0] pool [12];
        logic [15:0] nm;
        logic [2:0]  op;
        logic [7:0]  ix;
        logic [8:0]  sz;
        int r;
        int q;
        int row;
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        pool[2] = 16'h5555;
        pool[3] = 16'hAAAA;
        for (int k = 4; k < 12; k++) begin
            pool[k] = 16'($urandom);
        end
        for (int n = 0; n < n_words; n++) begin
            // A long stretch runs with both sides always ready.
            if (n == n_words / 4) begin
                idle_pct = 0;
                stall_pct = 0;
            end
            if (n == n_words / 4 + 300) begin
                idle_pct = 16;
                stall_pct = 16;
            end
            if (n == n_words / 2) begin
                wait_results();
            end

            // Pops grow likelier as the entry table fills.
            r = $urandom_range(99);
            q = int'(row_count) / 4;
            if (scope_depth == 0 && r < 85) begin
                op = OP_PUSH;
            end else if (r < 10) begin
                op = OP_PUSH;
            end else if (r < 20 + q) begin
                op = OP_POP;
            end else if (r < 40 + q) begin
                op = OP_DEFINE;
            end else if (r < 96) begin
                op = r[0] ? OP_READ : OP_WRITE;
            end else begin
                op = OP_SPARE_FIRST + 3'($urandom_range(2));
            end

            nm = ($urandom_range(99) < 10) ? 16'($urandom) : pool[$urandom_range(11)];
            if (op != OP_DEFINE && row_count != 0 && $urandom_range(99) < 70) begin
                nm = row_name[$urandom_range(int'(row_count) - 1)];
            end
            row = find_row(nm, 0);
            if (row >= 0 && $urandom_range(99) < 85) begin
                ix = 8'($urandom_range(int'(row_len[row]) - 1));
            end else begin
                ix = 8'($urandom);
            end

            r = $urandom_range(99);
            if (r < 70) begin
                sz = 9'($urandom_range(8, 1));
            end else if (r < 90) begin
                sz = 9'($urandom_range(64, 9));
            end else if (r < 96) begin
                sz = 9'($urandom_range(MAX_ARRAY, 65));
            end else begin
                sz = 9'($urandom);
            end

            send_word(op, nm, ix, 32'($urandom), sz);
        end
    endtask

    // The result side stalls at random.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Each result word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result word with no prediction waiting: read_value %0h status %0d",
                       o_read_value, o_status);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (o_read_value !== want.value) begin
                    $error("read_value: expected %0h, got %0h", want.value, o_read_value);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends a hung run: counts busy cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || !(i_in_valid || expected_results.size() != 0)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_frame_limit();
        test_storage_limit();
        test_random(1300);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d words and checked %0d results: errors with no frame, define checks,",
                 words_sent, results_checked);
        $display("shadowed names, frame/entry/storage exhaustion and random scoped sessions.");
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/svfs_pkg.sv
design/svfs_ram.sv
design/svfs_search.sv
design/scoped_variable_frame_stack_core.sv
design/svfs_checker.sv
tb/testbench.sv
